// File: rtl/gbd_pkg.sv
package gbd_pkg;

	localparam int WORD_BITS  = 32;
	localparam int KEPT_BITS  = 64;
	localparam int WIN_BITS   = KEPT_BITS + WORD_BITS;
	localparam int MAX_WANT   = 32;
	localparam int MAX_WIDTH  = 32;
	localparam int ONES_LIMIT = 32;

	localparam int LEN_W  = $clog2(WIN_BITS + 1);
	localparam int NB_W   = 6;
	localparam int CNT_W  = 6;
	localparam int ONES_W = $clog2(ONES_LIMIT);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WIN_BITS-1:0]  win_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_PREFIX   = 2'd1,
		FAULT_OVERFLOW = 2'd2
	} fault_t;

	typedef enum logic {
		KIND_GAMMA  = 1'b0,
		KIND_BINARY = 1'b1
	} kind_t;

	// Commands from the sequencer to the bit window.
	typedef struct packed {
		logic load;
		logic merge;
		logic start;
		logic shift;
		logic commit;
		logic trim;
	} win_ctrl_t;

	// Status from the bit window back to the sequencer.
	typedef struct packed {
		logic front;
		logic empty;
		logic over;
	} win_stat_t;

endpackage

// File: rtl/gbd_in_if.sv
interface gbd_in_if;
	import gbd_pkg::*;

	logic              valid;
	logic              ready;
	word_t             word;
	logic [NB_W-1:0]   bit_count;
	logic [NB_W-1:0]   want;
	logic              code_kind;
	logic [NB_W-1:0]   binary_width;

	modport source (
		output valid, word, bit_count, want, code_kind, binary_width,
		input  ready
	);

	modport sink (
		input  valid, word, bit_count, want, code_kind, binary_width,
		output ready
	);
endinterface

// File: rtl/gbd_out_if.sv
interface gbd_out_if;
	import gbd_pkg::*;

	logic       valid;
	logic       ready;
	word_t      value;
	logic       value_valid;
	logic       last;
	logic       satisfied;
	logic [1:0] fault;

	modport source (
		output valid, value, value_valid, last, satisfied, fault,
		input  ready
	);

	modport sink (
		input  valid, value, value_valid, last, satisfied, fault,
		output ready
	);
endinterface

// File: rtl/gbd_bitwin.sv
module gbd_bitwin (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gbd_pkg::win_ctrl_t        ctrl,
	input  gbd_pkg::word_t            word,
	input  logic [gbd_pkg::NB_W-1:0]  bit_count,
	output gbd_pkg::win_stat_t        stat
);
	import gbd_pkg::*;

	win_t            win_q;
	len_t            len_q;
	win_t            w_q;
	len_t            wlen_q;
	word_t           new_q;
	logic [NB_W-1:0] nb_q;

	logic [NB_W-1:0] nb_sat;
	win_t            w_nxt;
	len_t            wlen_nxt;
	win_t            new_placed;

	assign nb_sat = (bit_count > NB_W'(WORD_BITS)) ? NB_W'(WORD_BITS) : bit_count;

	assign w_nxt    = ctrl.shift ? {w_q[WIN_BITS-2:0], 1'b0} : w_q;
	assign wlen_nxt = ctrl.shift ? (wlen_q - len_t'(1)) : wlen_q;

	// New bits sit just behind the kept bits; everything past len_q is zero.
	assign new_placed = {new_q, {(WIN_BITS-WORD_BITS){1'b0}}} >> len_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			new_q <= word << (NB_W'(WORD_BITS) - nb_sat);
			nb_q  <= nb_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			len_q <= '0;
		end else begin
			if (ctrl.merge) begin
				win_q <= win_q | new_placed;
				len_q <= len_q + len_t'(nb_q);
			end else if (ctrl.commit) begin
				win_q <= w_nxt;
				len_q <= wlen_nxt;
			end else if (ctrl.trim) begin
				if (len_q > len_t'(KEPT_BITS)) begin
					len_q                           <= len_t'(KEPT_BITS);
					win_q[WIN_BITS-KEPT_BITS-1:0] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			w_q    <= win_q;
			wlen_q <= len_q;
		end else begin
			w_q    <= w_nxt;
			wlen_q <= wlen_nxt;
		end
	end

	assign stat.front = w_q[WIN_BITS-1];
	assign stat.empty = (wlen_q == '0);
	assign stat.over  = (len_q > len_t'(KEPT_BITS));

	a_merge_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.merge |-> (len_q <= len_t'(KEPT_BITS)))
		else $error("kept bits exceed the kept limit when new bits arrive");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |-> (wlen_q != '0))
		else $error("working window shifted while empty");

	a_commit_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> (len_q <= $past(len_q)))
		else $error("committing a code grew the window");

endmodule

// File: rtl/gbd_seq.sv
module gbd_seq (
	input  logic               clk,
	input  logic               arst_n,
	gbd_in_if.sink             in_ch,
	gbd_out_if.source          out_ch,
	output gbd_pkg::win_ctrl_t ctrl,
	input  gbd_pkg::win_stat_t stat
);
	import gbd_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MERGE  = 8'b0000_0010,
		ST_START  = 8'b0000_0100,
		ST_ONES   = 8'b0000_1000,
		ST_SUFFIX = 8'b0001_0000,
		ST_PUSH   = 8'b0010_0000,
		ST_TRIM   = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	cnt_t              want_q;
	kind_t             kind_q;
	cnt_t              bw_q;
	cnt_t              n_q;
	fault_t            fault_q;
	word_t             acc_q;
	cnt_t              rem_q;
	logic [ONES_W-1:0] ones_q;
	logic              pend_valid_q;
	word_t             pend_value_q;

	logic   out_valid_q;
	word_t  out_value_q;
	logic   out_vv_q;
	logic   out_last_q;
	logic   out_sat_q;
	fault_t out_fault_q;

	logic  accept, out_free, sat;
	logic  do_begin, count_one, to_suffix, suffix_bit, do_push;
	logic  emit_mid, emit_final, set_prefix, set_overflow;
	cnt_t  want_sat, bw_sat;
	word_t value_nxt;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign sat      = (n_q == want_q) && (want_q != '0);

	assign want_sat = (in_ch.want > cnt_t'(MAX_WANT)) ? cnt_t'(MAX_WANT) : in_ch.want;

	always_comb begin
		if (in_ch.binary_width == '0) begin
			bw_sat = cnt_t'(1);
		end else if (in_ch.binary_width > cnt_t'(MAX_WIDTH)) begin
			bw_sat = cnt_t'(MAX_WIDTH);
		end else begin
			bw_sat = in_ch.binary_width;
		end
	end

	// Gamma codes carry an implied leading one and an offset of one.
	assign value_nxt = acc_q - {{(WORD_BITS-1){1'b0}}, (kind_q == KIND_GAMMA)};

	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		do_begin     = 1'b0;
		count_one    = 1'b0;
		to_suffix    = 1'b0;
		suffix_bit   = 1'b0;
		do_push      = 1'b0;
		emit_mid     = 1'b0;
		emit_final   = 1'b0;
		set_prefix   = 1'b0;
		set_overflow = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.load = 1'b1;
					state_d   = ST_MERGE;
				end
			end
			ST_MERGE: begin
				ctrl.merge = 1'b1;
				state_d    = ST_START;
			end
			ST_START: begin
				if (n_q == want_q) begin
					state_d = ST_TRIM;
				end else begin
					ctrl.start = 1'b1;
					do_begin   = 1'b1;
					state_d    = (kind_q == KIND_GAMMA) ? ST_ONES : ST_SUFFIX;
				end
			end
			ST_ONES: begin
				if (stat.empty) begin
					state_d = ST_TRIM;
				end else if (stat.front) begin
					ctrl.shift = 1'b1;
					if (ones_q == ONES_W'(ONES_LIMIT - 1)) begin
						ctrl.commit = 1'b1;
						set_prefix  = 1'b1;
						state_d     = ST_TRIM;
					end else begin
						count_one = 1'b1;
					end
				end else begin
					ctrl.shift = 1'b1;
					to_suffix  = 1'b1;
					state_d    = ST_SUFFIX;
				end
			end
			ST_SUFFIX: begin
				if (rem_q == '0) begin
					state_d = ST_PUSH;
				end else if (stat.empty) begin
					state_d = ST_TRIM;
				end else begin
					ctrl.shift = 1'b1;
					suffix_bit = 1'b1;
				end
			end
			ST_PUSH: begin
				if (!pend_valid_q || out_free) begin
					do_push     = 1'b1;
					emit_mid    = pend_valid_q;
					ctrl.commit = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_TRIM: begin
				ctrl.trim    = 1'b1;
				set_overflow = (fault_q == FAULT_NONE) && stat.over;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if ((fault_q == FAULT_PREFIX) && pend_valid_q) begin
					emit_mid = out_free;
				end else if ((fault_q != FAULT_NONE) || pend_valid_q) begin
					if (out_free) begin
						emit_final = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			fault_q      <= FAULT_NONE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				n_q     <= '0;
				fault_q <= FAULT_NONE;
			end else begin
				if (do_push) begin
					n_q <= n_q + cnt_t'(1);
				end
				if (set_prefix) begin
					fault_q <= FAULT_PREFIX;
				end else if (set_overflow) begin
					fault_q <= FAULT_OVERFLOW;
				end
			end
			if (do_push) begin
				pend_valid_q <= 1'b1;
			end else if (emit_mid || emit_final) begin
				pend_valid_q <= 1'b0;
			end
			if (emit_mid || emit_final) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			want_q <= want_sat;
			kind_q <= kind_t'(in_ch.code_kind);
			bw_q   <= bw_sat;
		end
		if (do_begin) begin
			ones_q <= '0;
			rem_q  <= bw_q;
			acc_q  <= '0;
		end else if (count_one) begin
			ones_q <= ones_q + ONES_W'(1);
		end else if (to_suffix) begin
			rem_q <= cnt_t'(ones_q);
			acc_q <= word_t'(1);
		end else if (suffix_bit) begin
			acc_q <= {acc_q[WORD_BITS-2:0], stat.front};
			rem_q <= rem_q - cnt_t'(1);
		end
		if (do_push) begin
			pend_value_q <= value_nxt;
		end
		if (emit_mid) begin
			out_value_q <= pend_value_q;
			out_vv_q    <= 1'b1;
			out_last_q  <= 1'b0;
			out_sat_q   <= 1'b0;
			out_fault_q <= FAULT_NONE;
		end else if (emit_final) begin
			out_value_q <= pend_valid_q ? pend_value_q : '0;
			out_vv_q    <= pend_valid_q;
			out_last_q  <= 1'b1;
			out_sat_q   <= sat;
			out_fault_q <= fault_q;
		end
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.value       = out_value_q;
	assign out_ch.value_valid = out_vv_q;
	assign out_ch.last        = out_last_q;
	assign out_ch.satisfied   = out_sat_q;
	assign out_ch.fault       = out_fault_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("a decoded value was left behind at the end of an item");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) && (state_q != ST_MERGE) |-> (n_q <= want_q))
		else $error("more values decoded than wanted");

	a_empty_beat_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (!out_vv_q || (out_fault_q != FAULT_NONE)) |-> out_last_q)
		else $error("an empty or faulted beat is not the final one");

endmodule

// File: rtl/gamma_bitstream_decoder_core.sv
// Gamma bit-stream decoder. Each input beat appends up to 32 stream bits (the
// first stream bit in bit bit_count-1 of word) behind the bits kept from earlier
// beats, then decodes numbers from the front of that window until "want"
// numbers are out or no complete code remains. With code_kind 0 the codes are
// zero-origin gamma (k ones, a zero, k suffix bits, value 2^k + suffix - 1);
// with code_kind 1 they are plain binary numbers of binary_width bits. An
// incomplete trailing code stays behind as raw bits, so a later beat may read
// it under either kind. Each output beat carries one value; the final beat of
// an item has last set, satisfied set when a nonzero wanted count was reached, and a
// fault code: 1 when 32 ones start a gamma code (those ones are dropped and the
// item stops), 2 when more than 64 bits would be kept (the newest are dropped).
// A faulting item with no value to report yields one beat with value_valid 0;
// an item with neither values nor a fault yields no output beat at all.
// The decoder works on one item at a time: in_ch.ready is high only between
// items. While a code is read, the window is walked one bit per cycle by a
// single shift register. Besides its code bits, each value also takes a step
// to see that the code is complete, a step to hand the value over and a step
// to start the next code. Handing a value over may wait for the output side
// to take a beat. Results leave through an output register, so the next item
// is taken while the final beat of the previous one is still waiting.
module gamma_bitstream_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	gbd_in_if.sink     in_ch,
	gbd_out_if.source  out_ch
);
	import gbd_pkg::*;

	win_ctrl_t win_ctrl;
	win_stat_t win_stat;

	// Sequencer: code parsing, value accumulation, result ordering and the
	// output register.
	gbd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.ctrl   (win_ctrl),
		.stat   (win_stat)
	);

	// Bit window: kept bits plus the new word, and a working copy that is
	// shifted one bit per cycle while a code is read. The working copy is
	// committed back only when a code completes or its prefix faults, so a partial code is kept.
	gbd_bitwin u_bitwin (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.word      (in_ch.word),
		.bit_count (in_ch.bit_count),
		.stat      (win_stat)
	);

endmodule
